// ===== hw/rtl/rfa_pkg.sv =====
`timescale 1ns / 1ps
// rfa_pkg: shared types and constants of the ring fork arbiter
// no dependencies; used by rfa_nbr and ring_fork_arbiter_unit

package rfa_pkg;

	localparam int IDX_W           = 6;
	localparam int RING_W          = 7;
	localparam int STAT_W          = 2;
	localparam int MAX_CLIENTS_DEF = 64;
	localparam int RING_CAP_LIM    = 64;

	localparam logic [RING_W-1:0] RING_SIZE_RST = 7'd5;
	localparam logic [RING_W-1:0] RING_SIZE_MIN = 7'd2;

	// client status codes
	localparam logic [STAT_W-1:0] ST_THINKING = 2'd0;
	localparam logic [STAT_W-1:0] ST_HUNGRY   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EATING   = 2'd2;

	// operation codes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] client;
	} req_t;

	typedef struct packed {
		logic             self_granted;
		logic             left_granted;
		logic             right_granted;
		logic [IDX_W-1:0] left_index;
		logic [IDX_W-1:0] right_index;
		logic             bad_index;
	} rsp_t;

	// ring neighborhood of one client
	typedef struct packed {
		logic             bad;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] l;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] ll;
		logic [IDX_W-1:0] rr;
	} nbr_t;

endpackage

// ===== hw/rtl/rfa_ram.sv =====
`timescale 1ns / 1ps
// rfa_ram: generic single write port, single read port ram with registered read
// no dependencies

module rfa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/rfa_nbr.sv =====
`timescale 1ns / 1ps
// rfa_nbr: clamps the ring size and works out a client's ring neighbors
// depends on rfa_pkg

module rfa_nbr #(
	parameter int MAX_CLIENTS = rfa_pkg::MAX_CLIENTS_DEF
) (
	input  logic [rfa_pkg::IDX_W-1:0]  client,
	input  logic [rfa_pkg::RING_W-1:0] ring_size,
	output rfa_pkg::nbr_t              nbr
);

	import rfa_pkg::*;

	localparam int CAP = (MAX_CLIENTS < RING_CAP_LIM) ? MAX_CLIENTS : RING_CAP_LIM;

	logic [RING_W-1:0] n;

	function automatic logic [IDX_W-1:0] left_of(input logic [IDX_W-1:0] x,
			input logic [RING_W-1:0] sz);
		logic [RING_W-1:0] m;
		m = sz - 7'd1;
		if (x == '0) begin
			return m[IDX_W-1:0];
		end
		return x - 6'd1;
	endfunction

	function automatic logic [IDX_W-1:0] right_of(input logic [IDX_W-1:0] x,
			input logic [RING_W-1:0] sz);
		logic [RING_W-1:0] p;
		p = {1'b0, x} + 7'd1;
		if (p >= sz) begin
			return '0;
		end
		return p[IDX_W-1:0];
	endfunction

	// effective ring size, saturated into 2 .. cap
	always_comb begin
		if (ring_size < RING_SIZE_MIN) begin
			n = RING_SIZE_MIN;
		end else if (ring_size > RING_W'(CAP)) begin
			n = RING_W'(CAP);
		end else begin
			n = ring_size;
		end
	end

	always_comb begin
		nbr.bad = ({1'b0, client} >= n);
		nbr.c   = client;
		nbr.l   = left_of(client, n);
		nbr.r   = right_of(client, n);
		nbr.ll  = left_of(nbr.l, n);
		nbr.rr  = right_of(nbr.r, n);
	end

endmodule

// ===== hw/rtl/ring_fork_arbiter_unit.sv =====
`timescale 1ns / 1ps
// ring_fork_arbiter_unit: top level of the ring fork arbiter
// depends on rfa_pkg, rfa_ram, rfa_nbr

// Arbiter for a ring of clients that each share one resource with both ring
// neighbors. Every client's status (thinking, hungry, eating) lives in one
// synchronous status ram. A request word marks the client hungry and grants it
// when neither neighbor eats; a release word marks it thinking and retests the
// left, then the right neighbor. After reset the block sweeps the status ram
// to thinking, one entry a cycle over min(MAX_CLIENTS, 64) entries, and holds
// off requests meanwhile (ring_size writes are taken throughout). One word is
// handled at a time, as the status ram has a single read and write port: a
// valid client passes four ram reads of the neighborhood, one settle state,
// three write-back steps and the result state, and only then can the next
// word be taken; an index at or beyond the ring size goes straight to the
// result state and is reported with bad_index and no state change. The result
// register lets the next word be accepted while a result still waits on
// rsp_stall; a word only waits in its result cycle while the previous result
// is still stalled. ring_size is written through cfg_valid/cfg_ready (always
// ready) and should only change while the block is idle; values outside
// 2 .. min(MAX_CLIENTS, 64) saturate.

module ring_fork_arbiter_unit #(
	parameter int MAX_CLIENTS = rfa_pkg::MAX_CLIENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request words
	input  logic                       req_valid,
	output logic                       req_stall,
	input  rfa_pkg::req_t              req,
	// result words
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output rfa_pkg::rsp_t              rsp,
	// ring size register
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rfa_pkg::RING_W-1:0] cfg_data
);

	import rfa_pkg::*;

	localparam int CAP = (MAX_CLIENTS < RING_CAP_LIM) ? MAX_CLIENTS : RING_CAP_LIM;
	localparam int AW  = $clog2(CAP);

	// sequencer states
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_LAST = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	// read slots of the neighborhood
	localparam logic [1:0] SL_L  = 2'd0;
	localparam logic [1:0] SL_R  = 2'd1;
	localparam logic [1:0] SL_LL = 2'd2;
	localparam logic [1:0] SL_RR = 2'd3;

	logic [2:0]        state_q;
	logic [RING_W-1:0] ring_size_q;
	logic [AW-1:0]     clr_q;
	logic [1:0]        cnt_q;
	logic              rd_vld_q;
	logic [1:0]        rd_sel_q;
	logic              op_q;
	nbr_t              nbr_q;
	nbr_t              nbr;
	logic [STAT_W-1:0] st_q [4];
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [STAT_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [STAT_W-1:0] ram_rdata;

	logic eat_l, eat_r, eat_ll, eat_rr, hun_l, hun_r;
	logic self_g, left_g, right_g, rr_eats;
	logic out_free;

	// ring size register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= RING_SIZE_RST;
		end else if (cfg_valid) begin
			ring_size_q <= cfg_data;
		end
	end

	// neighborhood of the incoming client
	rfa_nbr #(
		.MAX_CLIENTS(MAX_CLIENTS)
	) u_nbr (
		.client   (req.client),
		.ring_size(ring_size_q),
		.nbr      (nbr)
	);

	// status ram
	rfa_ram #(
		.WIDTH(STAT_W),
		.DEPTH(CAP)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// read address per slot
	always_comb begin
		ram_re = (state_q == S_RD);
		case (cnt_q)
			SL_L:    ram_raddr = nbr_q.l[AW-1:0];
			SL_R:    ram_raddr = nbr_q.r[AW-1:0];
			SL_LL:   ram_raddr = nbr_q.ll[AW-1:0];
			SL_RR:   ram_raddr = nbr_q.rr[AW-1:0];
			default: ram_raddr = nbr_q.l[AW-1:0];
		endcase
	end

	// grant tests on the captured neighborhood; the client itself is
	// already hungry (request) or thinking (release)
	always_comb begin
		eat_l  = (st_q[SL_L] == ST_EATING);
		eat_r  = (st_q[SL_R] == ST_EATING);
		eat_ll = (st_q[SL_LL] == ST_EATING);
		eat_rr = (st_q[SL_RR] == ST_EATING);
		hun_l  = (st_q[SL_L] == ST_HUNGRY);
		hun_r  = (st_q[SL_R] == ST_HUNGRY);
		self_g = !eat_l && !eat_r;
		// on a ring of two the left's left is the releasing client
		left_g = hun_l && !((nbr_q.ll != nbr_q.c) && eat_ll);
		// the right's right may be the left neighbor just granted
		rr_eats = (nbr_q.rr == nbr_q.l) ? (left_g || eat_l) : eat_rr;
		right_g = (nbr_q.r != nbr_q.l) && hun_r && !rr_eats;
	end

	// write-back: client, then left and right on a release
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = nbr_q.c[AW-1:0];
		ram_wdata = ST_THINKING;
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (state_q == S_WR) begin
			case (cnt_q)
				2'd0: begin
					ram_we    = 1'b1;
					ram_waddr = nbr_q.c[AW-1:0];
					if (op_q == OP_REQUEST) begin
						ram_wdata = self_g ? ST_EATING : ST_HUNGRY;
					end
				end
				2'd1: begin
					ram_we    = (op_q == OP_RELEASE) && left_g;
					ram_waddr = nbr_q.l[AW-1:0];
					ram_wdata = ST_EATING;
				end
				2'd2: begin
					ram_we    = (op_q == OP_RELEASE) && right_g;
					ram_waddr = nbr_q.r[AW-1:0];
					ram_wdata = ST_EATING;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rd_vld_q    <= 1'b0;
			rd_sel_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == S_RD);
			rd_sel_q <= cnt_q;
			// result register: loaded in the result cycle, freed when taken
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CAP - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (req_valid) begin
						state_q <= nbr.bad ? S_OUT : S_RD;
					end
				end
				S_RD: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == SL_RR) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					cnt_q   <= '0;
					state_q <= S_WR;
				end
				S_WR: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			op_q  <= req.op;
			nbr_q <= nbr;
		end
		if (rd_vld_q) begin
			st_q[rd_sel_q] <= ram_rdata;
		end
		// the word only moves into the result register once it is free
		if (state_q == S_OUT && out_free) begin
			if (nbr_q.bad) begin
				rsp_q.bad_index     <= 1'b1;
				rsp_q.left_index    <= '0;
				rsp_q.right_index   <= '0;
				rsp_q.self_granted  <= 1'b0;
				rsp_q.left_granted  <= 1'b0;
				rsp_q.right_granted <= 1'b0;
			end else begin
				rsp_q.bad_index     <= 1'b0;
				rsp_q.left_index    <= nbr_q.l;
				rsp_q.right_index   <= nbr_q.r;
				rsp_q.self_granted  <= (op_q == OP_REQUEST) && self_g;
				rsp_q.left_granted  <= (op_q == OP_RELEASE) && left_g;
				rsp_q.right_granted <= (op_q == OP_RELEASE) && right_g;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a bad index reports nothing else
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_index |-> !rsp.self_granted && !rsp.left_granted &&
			!rsp.right_granted && rsp.left_index == '0 && rsp.right_index == '0)
		else $error("bad index result carries grants or indices");

	// a request grant and a release grant never share one result
	a_grant_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.self_granted |-> !rsp.left_granted && !rsp.right_granted)
		else $error("self grant mixed with neighbor grant");

	// on a ring of two only the left test can grant
	a_pair_once: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.bad_index && rsp.left_index == rsp.right_index |->
			!rsp.right_granted)
		else $error("shared neighbor granted twice");

	// one word in flight: the next cycle after acceptance stalls
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second word accepted back to back");

	// nothing is reported while the status ram is being cleared
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !rsp_valid)
		else $error("result during clearing pass");

endmodule
